/* hw/rtl/usdt_pkg.sv */
// Shared codes, types and reset constants for the datagram socket table.
`timescale 1ns / 1ps
package usdt_pkg;

	localparam int SOCKETS_DEF  = 16;
	localparam int RX_SLOTS_DEF = 4;

	localparam logic [15:0] RESET_SOURCE_PORT   = 16'd49152;
	localparam logic [10:0] RESET_PAYLOAD_LIMIT = 11'd1472;

	typedef enum logic [2:0] {
		REQ_OPEN    = 3'd0,
		REQ_BIND    = 3'd1,
		REQ_CONNECT = 3'd2,
		REQ_DELIVER = 3'd3,
		REQ_RECEIVE = 3'd4,
		REQ_CLOSE   = 3'd5,
		REQ_SEND    = 3'd6,
		REQ_UNKNOWN = 3'd7
	} req_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_BAD_SOCKET = 3'd1,
		ST_TABLE_FULL = 3'd2,
		ST_BAD_ARG    = 3'd3,
		ST_EMPTY      = 3'd4,
		ST_DROPPED    = 3'd5,
		ST_NO_MATCH   = 3'd6,
		ST_UNRESOLVED = 3'd7
	} status_t;

	typedef enum logic [0:0] {
		CFG_SOURCE_PORT   = 1'b0,
		CFG_PAYLOAD_LIMIT = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_DISP,
		FSM_OPEN_SCAN,
		FSM_DLV_CHK,
		FSM_ENT_CHK,
		FSM_SLOT_CHK
	} fsm_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  sock;
		logic [1:0]  slot;
		logic [15:0] len;
		logic [31:0] addr;
		logic [15:0] rport;
		logic [15:0] sport;
		logic        can_rx;
	} res_t;

endpackage

/* hw/rtl/udp_socket_demux_table_unit.sv */
// Top level: datagram socket table with entry and slot memories.
`timescale 1ns / 1ps
// channel  | signals                                   | handshake
// ---------+-------------------------------------------+---------------------------
// request  | req_type socket_index peer_address ...    | start && !busy
// result   | status socket_out slot_out length_out ... | done strobe, one cycle
// config   | cfg_we cfg_index cfg_data                 | cfg_we, any cycle idle
// One word at a time. Bind, connect, close, send and unknown on a live entry pass dispatch
// and the entry check; receive adds a slot read when its length is nonzero and the tail
// slot is full; open scans entries from index 0 to the first free one; deliver scans them to the first match.
// Refused at dispatch: bad socket, zero deliver length, unknown on a free entry.
// Reset clears in-use and slot-full flags at once; no clearing pass.
// The receiver cannot stall; busy falls as the done strobe rises.
module udp_socket_demux_table_unit #(
	parameter int SOCKETS  = usdt_pkg::SOCKETS_DEF,
	parameter int RX_SLOTS = usdt_pkg::RX_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  req_type,
	input  logic [3:0]  socket_index,
	input  logic [31:0] peer_address,
	input  logic        address_given,
	input  logic [15:0] peer_port,
	input  logic [15:0] local_port,
	input  logic [15:0] byte_count,
	output logic        done,
	output logic [2:0]  status,
	output logic [3:0]  socket_out,
	output logic [1:0]  slot_out,
	output logic [15:0] length_out,
	output logic [31:0] address_out,
	output logic [15:0] remote_port_out,
	output logic [15:0] source_port_out,
	output logic        can_receive,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int IW     = $clog2(SOCKETS);
	localparam int RW     = $clog2(RX_SLOTS);
	localparam int NSLOT  = SOCKETS * RX_SLOTS;
	localparam int SW     = $clog2(NSLOT);

	typedef struct packed {
		logic [15:0]   bound;
		logic [31:0]   raddr;
		logic [15:0]   rport;
		logic          conn;
		logic [RW-1:0] head;
		logic [RW-1:0] tail;
	} ent_t;

	typedef struct packed {
		logic [10:0] len;
		logic [31:0] addr;
		logic [15:0] port;
	} slot_t;

	function automatic logic [SW-1:0] slot_addr(input logic [IW-1:0] e,
		input logic [RW-1:0] p);
		slot_addr = SW'(SW'(e) * SW'(RX_SLOTS)) + SW'(p);
	endfunction

	function automatic logic [RW-1:0] ring_next(input logic [RW-1:0] p);
		ring_next = (p == RW'(RX_SLOTS - 1)) ? '0 : RW'(p + 1'b1);
	endfunction

	// configuration
	logic [15:0] dflt_port_q;
	logic [10:0] limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dflt_port_q <= usdt_pkg::RESET_SOURCE_PORT;
			limit_q     <= usdt_pkg::RESET_PAYLOAD_LIMIT;
		end else if (cfg_we) begin
			case (usdt_pkg::cfg_idx_t'(cfg_index))
				usdt_pkg::CFG_SOURCE_PORT:   dflt_port_q <= cfg_data;
				usdt_pkg::CFG_PAYLOAD_LIMIT: limit_q     <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	// latched request word
	logic [2:0]  req_q;
	logic [3:0]  idx_in_q;
	logic [31:0] paddr_q;
	logic        given_q;
	logic [15:0] pport_q;
	logic [15:0] lport_q;
	logic [15:0] count_q;

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_q    <= req_type;
			idx_in_q <= socket_index;
			paddr_q  <= peer_address;
			given_q  <= address_given;
			pport_q  <= peer_port;
			lport_q  <= local_port;
			count_q  <= byte_count;
		end
	end

	logic          idx_ok;
	logic [IW-1:0] idx;
	assign idx_ok = {5'd0, idx_in_q} < 9'(SOCKETS);
	assign idx    = IW'(idx_in_q);

	// flag flops and memories
	logic [SOCKETS-1:0] in_use_q;
	logic [NSLOT-1:0]   full_q;
	ent_t               ent_mem [SOCKETS];
	slot_t              slot_mem [NSLOT];
	ent_t               ent_rd_q;
	slot_t              slot_rd_q;

	usdt_pkg::fsm_t st_q, st_d;
	logic [IW-1:0]  cnt_q;

	// action signals
	logic          ent_re, ent_we, slot_re, slot_we;
	logic [IW-1:0] ent_raddr, ent_waddr;
	ent_t          ent_wdata;
	logic [SW-1:0] slot_raddr, slot_waddr;
	slot_t         slot_wdata;
	logic          use_set, use_clr, full_set, full_clr, row_clr;
	logic [IW-1:0] use_e, row_e;
	logic [SW-1:0] full_a;
	logic          fin, cnt_clr, cnt_inc;
	usdt_pkg::res_t res;

	logic          dlv_match, cnt_last;
	logic [SW-1:0] head_a, tail_a;
	logic [RW-1:0] nxt;
	logic [15:0]   clip;
	logic          have;
	logic [31:0]   daddr;
	logic [15:0]   dport, slen;

	assign cnt_last  = cnt_q == IW'(SOCKETS - 1);
	assign dlv_match = in_use_q[cnt_q]
		&& (ent_rd_q.bound == '0 || ent_rd_q.bound == lport_q)
		&& (!ent_rd_q.conn || (ent_rd_q.rport == pport_q && ent_rd_q.raddr == paddr_q));
	assign clip = (count_q < {5'd0, limit_q}) ? count_q : {5'd0, limit_q};
	assign slen = {5'd0, slot_rd_q.len};

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			usdt_pkg::FSM_IDLE: if (start) st_d = usdt_pkg::FSM_DISP;
			usdt_pkg::FSM_DISP: begin
				case (usdt_pkg::req_t'(req_q))
					usdt_pkg::REQ_OPEN:    st_d = usdt_pkg::FSM_OPEN_SCAN;
					usdt_pkg::REQ_DELIVER:
						st_d = (count_q == '0) ? usdt_pkg::FSM_IDLE : usdt_pkg::FSM_DLV_CHK;
					default:
						st_d = (idx_ok && in_use_q[idx]) ? usdt_pkg::FSM_ENT_CHK
							: usdt_pkg::FSM_IDLE;
				endcase
			end
			usdt_pkg::FSM_OPEN_SCAN:
				if (!in_use_q[cnt_q] || cnt_last) st_d = usdt_pkg::FSM_IDLE;
			usdt_pkg::FSM_DLV_CHK:
				if (dlv_match || cnt_last) st_d = usdt_pkg::FSM_IDLE;
			usdt_pkg::FSM_ENT_CHK: begin
				if (usdt_pkg::req_t'(req_q) == usdt_pkg::REQ_RECEIVE && count_q != '0
					&& full_q[slot_addr(idx, ent_rd_q.tail)])
					st_d = usdt_pkg::FSM_SLOT_CHK;
				else
					st_d = usdt_pkg::FSM_IDLE;
			end
			usdt_pkg::FSM_SLOT_CHK: st_d = usdt_pkg::FSM_IDLE;
			default: st_d = usdt_pkg::FSM_IDLE;
		endcase
	end

	// actions and result
	always_comb begin
		ent_re = 1'b0; ent_raddr = '0; ent_we = 1'b0; ent_waddr = '0; ent_wdata = ent_rd_q;
		slot_re = 1'b0; slot_raddr = '0; slot_we = 1'b0; slot_waddr = '0;
		slot_wdata = '{len: clip[10:0], addr: paddr_q, port: pport_q};
		use_set = 1'b0; use_clr = 1'b0; use_e = '0;
		full_set = 1'b0; full_clr = 1'b0; full_a = '0; row_clr = 1'b0; row_e = '0;
		fin = 1'b0; cnt_clr = 1'b0; cnt_inc = 1'b0;
		res = '0;
		head_a = slot_addr(cnt_q, ent_rd_q.head);
		tail_a = slot_addr(cnt_q, ent_rd_q.tail);
		nxt = ring_next(ent_rd_q.head);
		have = given_q; daddr = paddr_q; dport = pport_q;
		case (st_q)
			usdt_pkg::FSM_DISP: begin
				cnt_clr = 1'b1;
				case (usdt_pkg::req_t'(req_q))
					usdt_pkg::REQ_OPEN: ;
					usdt_pkg::REQ_DELIVER: begin
						if (count_q == '0) begin
							fin = 1'b1;
							res.status = usdt_pkg::ST_BAD_ARG;
						end else begin
							ent_re = 1'b1;
						end
					end
					usdt_pkg::REQ_UNKNOWN: begin
						// a live entry still reports can_receive from its tail slot
						if (idx_ok && in_use_q[idx]) begin
							ent_re = 1'b1;
							ent_raddr = idx;
						end else begin
							fin = 1'b1;
							res.status = usdt_pkg::ST_BAD_ARG;
						end
					end
					default: begin
						if (idx_ok && in_use_q[idx]) begin
							ent_re = 1'b1;
							ent_raddr = idx;
						end else begin
							fin = 1'b1;
							res.status = usdt_pkg::ST_BAD_SOCKET;
						end
					end
				endcase
			end
			usdt_pkg::FSM_OPEN_SCAN: begin
				cnt_inc = 1'b1;
				if (!in_use_q[cnt_q]) begin
					fin = 1'b1;
					use_set = 1'b1; use_e = cnt_q;
					row_clr = 1'b1; row_e = cnt_q;
					ent_we = 1'b1; ent_waddr = cnt_q; ent_wdata = '0;
					res.sock = 4'(cnt_q);
				end else if (cnt_last) begin
					fin = 1'b1;
					res.status = usdt_pkg::ST_TABLE_FULL;
				end
			end
			usdt_pkg::FSM_DLV_CHK: begin
				cnt_inc = 1'b1;
				if (dlv_match) begin
					fin = 1'b1;
					res.sock = 4'(cnt_q);
					if (full_q[head_a]) begin
						res.status = usdt_pkg::ST_DROPPED;
						res.can_rx = full_q[tail_a];
					end else begin
						slot_we = 1'b1; slot_waddr = head_a;
						full_set = 1'b1; full_a = head_a;
						ent_we = 1'b1; ent_waddr = cnt_q; ent_wdata.head = nxt;
						res.slot = 2'(ent_rd_q.head);
						res.len = {5'd0, clip[10:0]};
						res.can_rx = full_q[tail_a] || (ent_rd_q.tail == ent_rd_q.head);
					end
				end else if (cnt_last) begin
					fin = 1'b1;
					res.status = usdt_pkg::ST_NO_MATCH;
				end else begin
					ent_re = 1'b1;
					ent_raddr = IW'(cnt_q + 1'b1);
				end
			end
			usdt_pkg::FSM_ENT_CHK: begin
				tail_a = slot_addr(idx, ent_rd_q.tail);
				res.sock = idx_in_q;
				res.can_rx = full_q[tail_a];
				fin = 1'b1;
				case (usdt_pkg::req_t'(req_q))
					usdt_pkg::REQ_BIND: begin
						ent_we = 1'b1; ent_waddr = idx; ent_wdata.bound = lport_q;
					end
					usdt_pkg::REQ_CONNECT: begin
						if (pport_q == '0) begin
							res.status = usdt_pkg::ST_BAD_ARG;
						end else begin
							ent_we = 1'b1; ent_waddr = idx;
							ent_wdata.raddr = paddr_q;
							ent_wdata.rport = pport_q;
							ent_wdata.conn = 1'b1;
						end
					end
					usdt_pkg::REQ_RECEIVE: begin
						if (count_q == '0) begin
							res.status = usdt_pkg::ST_BAD_ARG;
						end else if (!full_q[tail_a]) begin
							res.status = usdt_pkg::ST_EMPTY;
						end else begin
							fin = 1'b0;
							slot_re = 1'b1; slot_raddr = tail_a;
						end
					end
					usdt_pkg::REQ_CLOSE: begin
						use_clr = 1'b1; use_e = idx;
						row_clr = 1'b1; row_e = idx;
						res.can_rx = 1'b0;
					end
					usdt_pkg::REQ_UNKNOWN: begin
						res.status = usdt_pkg::ST_BAD_ARG;
						res.sock = '0;
					end
					default: begin
						if (count_q == '0) begin
							res.status = usdt_pkg::ST_BAD_ARG;
						end else begin
							if ((!have || dport == '0) && ent_rd_q.conn) begin
								have = 1'b1;
								daddr = ent_rd_q.raddr;
								dport = ent_rd_q.rport;
							end
							if (!have || dport == '0) begin
								res.status = usdt_pkg::ST_UNRESOLVED;
							end else begin
								res.addr = daddr;
								res.rport = dport;
								res.sport = (ent_rd_q.bound != '0) ? ent_rd_q.bound
									: dflt_port_q;
								res.len = count_q;
							end
						end
					end
				endcase
			end
			usdt_pkg::FSM_SLOT_CHK: begin
				tail_a = slot_addr(idx, ent_rd_q.tail);
				nxt = ring_next(ent_rd_q.tail);
				fin = 1'b1;
				full_clr = 1'b1; full_a = tail_a;
				ent_we = 1'b1; ent_waddr = idx; ent_wdata.tail = nxt;
				res.sock = idx_in_q;
				res.slot = 2'(ent_rd_q.tail);
				res.len = (slen < count_q) ? slen : count_q;
				res.addr = slot_rd_q.addr;
				res.rport = slot_rd_q.port;
				res.can_rx = full_q[slot_addr(idx, nxt)];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= usdt_pkg::FSM_IDLE;
			cnt_q    <= '0;
			in_use_q <= '0;
			full_q   <= '0;
			done     <= 1'b0;
		end else begin
			st_q <= st_d;
			done <= fin;
			if (cnt_clr) cnt_q <= '0;
			else if (cnt_inc) cnt_q <= IW'(cnt_q + 1'b1);
			if (use_set) in_use_q[use_e] <= 1'b1;
			if (use_clr) in_use_q[use_e] <= 1'b0;
			if (row_clr) begin
				for (int j = 0; j < RX_SLOTS; j++)
					full_q[slot_addr(row_e, RW'(j))] <= 1'b0;
			end
			if (full_set) full_q[full_a] <= 1'b1;
			if (full_clr) full_q[full_a] <= 1'b0;
		end
	end

	// result word and memories
	always_ff @(posedge clk) begin
		if (fin) begin
			status          <= res.status;
			socket_out      <= res.sock;
			slot_out        <= res.slot;
			length_out      <= res.len;
			address_out     <= res.addr;
			remote_port_out <= res.rport;
			source_port_out <= res.sport;
			can_receive     <= res.can_rx;
		end
		if (ent_we) ent_mem[ent_waddr] <= ent_wdata;
		if (ent_re) ent_rd_q <= ent_mem[ent_raddr];
		if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
		if (slot_re) slot_rd_q <= slot_mem[slot_raddr];
	end

	assign busy = st_q != usdt_pkg::FSM_IDLE;

	a_done_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(st_q) != usdt_pkg::FSM_IDLE)
		else $error("result strobe without a request in flight");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted request did not raise busy");
	a_bad_sock_no_rx: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == usdt_pkg::ST_BAD_SOCKET) |-> !can_receive)
		else $error("can_receive set on a bad socket");
	a_open_single: assert property (@(posedge clk) disable iff (!arst_n)
		(use_set |-> !use_clr))
		else $error("entry set and cleared together");

endmodule
